// ----- design/cpq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cpq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int POS_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int COST_W = 24;
    localparam int TAG_W = 16;
    localparam int OUT_POS_W = 6;
    localparam int OUT_CNT_W = 7;

    localparam int PADDR_W = 4;
    localparam int IN_DATA_W = 64;
    localparam int OUT_DATA_W = 80;

    localparam logic [1:0] REG_LIFO_ORDER = 2'd0;
    localparam logic [1:0] REG_TIE_BREAK = 2'd1;
    localparam logic [1:0] REG_TIE_THRESHOLD = 2'd2;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [COST_W-1:0] heur;
        logic [COST_W-1:0] total;
    } t_entry;

    typedef struct packed {
        logic       lifo;
        logic       tie_break;
        logic [7:0] threshold;
    } t_cfg;

    typedef struct packed {
        logic cmp;
        logic push;
        logic pop;
    } t_cell_ctl;

    // true when a must precede b
    function automatic logic goes_before(t_entry a, t_entry b, t_cfg cfg);
        logic [COST_W-1:0] diff;
        logic              near;
        diff = (a.total > b.total) ? (a.total - b.total) : (b.total - a.total);
        near = cfg.tie_break && (diff < COST_W'(cfg.threshold));
        return near ? (a.heur < b.heur) : (a.total < b.total);
    endfunction

endpackage

`default_nettype wire

// ----- design/cost_ordered_priority_queue_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser command, tdata entry
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata result
// apb       in   psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// Each word goes through three steps: latch, compare in every cell, then shift.
// The compare and shift run in the row of cells, one cell per queue slot.
// The result register frees the input side; a stalled result holds the shift.
// Synchronous active-low reset empties the queue and restores the registers.

module cost_ordered_priority_queue_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [1:0] command
    input  wire logic [1:0]                       s_axis_tuser,
    // [23:0] total_cost, [47:24] heuristic_cost, [63:48] entry_tag
    input  wire logic [cpq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [23:0] head_total_cost, [47:24] head_heuristic_cost, [63:48] head_tag,
    // [69:64] insert_position, [76:70] entry_count, [77] queue_empty,
    // [78] error, [79] zero
    output logic [cpq_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [cpq_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam int DEPTH = cpq_pkg::QUEUE_DEPTH;

    cpq_pkg::t_state    r_state, n_state;
    cpq_pkg::t_cfg      r_cfg;
    cpq_pkg::t_cmd      r_cmd;
    cpq_pkg::t_entry    r_new;
    logic [cpq_pkg::CNT_W-1:0] r_count, n_count;
    logic               r_out_valid;
    logic [cpq_pkg::OUT_DATA_W-1:0] r_out, n_out;

    cpq_pkg::t_cell_ctl ctl;
    cpq_pkg::t_entry    cell_entry [DEPTH];
    logic [DEPTH-1:0]   take_new;
    logic [DEPTH:0]     before_chain;
    logic [DEPTH-1:0]   slot_valid;

    logic               upd_fire;
    logic               full, empty, push_ok, read_ok;
    logic [cpq_pkg::POS_W-1:0] pos;
    cpq_pkg::t_entry    head;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lifo      <= 1'b0;
            r_cfg.tie_break <= 1'b0;
            r_cfg.threshold <= 8'd1;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                cpq_pkg::REG_LIFO_ORDER:    r_cfg.lifo      <= pwdata[0];
                cpq_pkg::REG_TIE_BREAK:     r_cfg.tie_break <= pwdata[0];
                cpq_pkg::REG_TIE_THRESHOLD: r_cfg.threshold <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            cpq_pkg::REG_LIFO_ORDER:    prdata = {31'd0, r_cfg.lifo};
            cpq_pkg::REG_TIE_BREAK:     prdata = {31'd0, r_cfg.tie_break};
            cpq_pkg::REG_TIE_THRESHOLD: prdata = {24'd0, r_cfg.threshold};
            default:                    prdata = 32'd0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            cpq_pkg::ST_IDLE: if (s_axis_tvalid) n_state = cpq_pkg::ST_CMP;
            cpq_pkg::ST_CMP:  n_state = cpq_pkg::ST_UPD;
            cpq_pkg::ST_UPD:  if (!r_out_valid || m_axis_tready) n_state = cpq_pkg::ST_IDLE;
            default:          n_state = cpq_pkg::ST_IDLE;
        endcase
    end

    assign full    = (r_count == cpq_pkg::CNT_W'(DEPTH));
    assign empty   = (r_count == '0);
    assign push_ok = (r_cmd == cpq_pkg::CMD_PUSH) && !full;
    assign read_ok = ((r_cmd == cpq_pkg::CMD_POP) || (r_cmd == cpq_pkg::CMD_PEEK)) && !empty;

    always_comb begin
        s_axis_tready = 1'b0;
        upd_fire      = 1'b0;
        ctl           = '0;
        case (r_state)
            cpq_pkg::ST_IDLE: s_axis_tready = 1'b1;
            cpq_pkg::ST_CMP:  ctl.cmp = 1'b1;
            cpq_pkg::ST_UPD: begin
                upd_fire = !r_out_valid || m_axis_tready;
                ctl.push = upd_fire && push_ok;
                ctl.pop  = upd_fire && read_ok && (r_cmd == cpq_pkg::CMD_POP);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd       <= cpq_pkg::t_cmd'(s_axis_tuser);
            r_new.total <= s_axis_tdata[23:0];
            r_new.heur  <= s_axis_tdata[47:24];
            r_new.tag   <= s_axis_tdata[63:48];
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            slot_valid[i] = (cpq_pkg::CNT_W'(i) < r_count);
        end
    end

    assign before_chain[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        cpq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_cfg      (r_cfg),
            .i_new      (r_new),
            .i_left     ((g == 0) ? r_new : cell_entry[(g == 0) ? 0 : g-1]),
            .i_right    ((g == DEPTH-1) ? cell_entry[g]
                                        : cell_entry[(g == DEPTH-1) ? g : g+1]),
            .i_valid    (slot_valid[g]),
            .i_before   (before_chain[g]),
            .o_before   (before_chain[g+1]),
            .o_take_new (take_new[g]),
            .o_entry    (cell_entry[g])
        );
    end

    always_comb begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            pos = pos | (take_new[i] ? cpq_pkg::POS_W'(i) : '0);
        end
    end

    assign head = read_ok ? cell_entry[0] : '0;

    always_comb begin
        n_count = r_count;
        case (r_cmd)
            cpq_pkg::CMD_PUSH:  if (!full) n_count = r_count + 1'b1;
            cpq_pkg::CMD_POP:   if (!empty) n_count = r_count - 1'b1;
            cpq_pkg::CMD_PEEK:  n_count = r_count;
            cpq_pkg::CMD_CLEAR: n_count = '0;
            default:            n_count = r_count;
        endcase
    end

    always_comb begin
        n_out = '0;
        n_out[23:0]  = head.total;
        n_out[47:24] = head.heur;
        n_out[63:48] = head.tag;
        n_out[69:64] = push_ok ? cpq_pkg::OUT_POS_W'(pos) : '0;
        n_out[76:70] = cpq_pkg::OUT_CNT_W'(n_count);
        n_out[77]    = (n_count == '0);
        n_out[78]    = ((r_cmd == cpq_pkg::CMD_PUSH) && full)
                     || (((r_cmd == cpq_pkg::CMD_POP) || (r_cmd == cpq_pkg::CMD_PEEK))
                         && empty);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (upd_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_fire) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

`default_nettype wire

// ----- design/cpq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cpq_cell (
    input  wire logic               i_clk,
    input  wire cpq_pkg::t_cell_ctl i_ctl,
    input  wire cpq_pkg::t_cfg      i_cfg,
    input  wire cpq_pkg::t_entry    i_new,
    input  wire cpq_pkg::t_entry    i_left,
    input  wire cpq_pkg::t_entry    i_right,
    input  wire logic               i_valid,
    input  wire logic               i_before,
    output logic                    o_before,
    output logic                    o_take_new,
    output cpq_pkg::t_entry         o_entry
);

    cpq_pkg::t_entry r_entry;
    logic            r_stop;
    logic            stop_now;
    logic            eff_stop;

    always_comb begin
        if (i_cfg.lifo) begin
            stop_now = !cpq_pkg::goes_before(r_entry, i_new, i_cfg);
        end else begin
            stop_now = cpq_pkg::goes_before(i_new, r_entry, i_cfg);
        end
    end

    assign eff_stop   = i_valid ? r_stop : 1'b1;
    assign o_before   = i_before | eff_stop;
    assign o_take_new = !i_before & eff_stop;
    assign o_entry    = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_stop <= stop_now;
        end
        if (i_ctl.push) begin
            if (i_before) begin
                r_entry <= i_left;
            end else if (eff_stop) begin
                r_entry <= i_new;
            end
        end else if (i_ctl.pop) begin
            r_entry <= i_right;
        end
    end

endmodule

`default_nettype wire
